### sv/bf3_pkg.sv
// Shared types and constants of the 3x3 box filter stream.
package bf3_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int ROW_W           = 13;
  localparam int COL_W           = 6;
  localparam int CFG_DATA_W      = 13;
  localparam int CFG_IDX_W       = 1;
  localparam int DEF_MAX_COLUMNS = 32;
  localparam int WIN_N           = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic [ROW_W-1:0] ROW_COUNT_RST    = 13'd4;
  localparam logic [COL_W-1:0] COLUMN_COUNT_RST = 6'd4;

  localparam int SUM_W      = 20;
  localparam int DIV_SHIFT  = 24;
  localparam int DIV_MUL_W  = 21;
  localparam int DIV9_MUL   = (1 << DIV_SHIFT) / 9 + 1;
  localparam int PROD_W     = SUM_W + DIV_MUL_W;

  typedef enum logic [1:0] {
    FL_IDLE,
    FL_PEND,
    FL_DRAIN
  } flush_state_t;

  typedef enum logic [1:0] {
    K_NORMAL,
    K_PEND,
    K_DRAIN
  } item_kind_t;

endpackage

### sv/box_filter_3x3_stream.sv
// 3x3 box filter over a raster sample stream with a line memory.
// Takes one unsigned Q8.8 sample per clock in raster order unless stalled and returns each
// interior sample as the floor of its 3x3 neighbourhood sum over nine, border samples
// unchanged, one row plus one sample behind the input. Within a frame one word is taken per
// cycle while out_tready holds, limited by the single read-modify-write of the line memory,
// which holds the two previous rows packed in one entry per column. After the last sample of
// a frame the input stalls while the last row is read back from the line memory and sent
// out; out_tlast marks the final word of the frame. From acceptance a word passes through
// stages s1, s2 and s3 into the output register. Configuration writes restart the frame and
// must only be made while the block is idle.
module box_filter_3x3_stream
  import bf3_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,    // [15:0] sample_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,   // [15:0] sample_out
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_COLUMNS);
  localparam logic [COL_W-1:0] MAX_COLS = COL_W'(MAX_COLUMNS);

  logic [ROW_W-1:0]      row_count_r;
  logic [COL_W-1:0]      column_count_r;
  logic [ROW_W-1:0]      rows_eff;
  logic [ROW_W-1:0]      row_last;
  logic [COL_W-1:0]      cols_eff;
  logic [COL_W-1:0]      cols_m1;
  logic [IDX_W-1:0]      col_last;

  logic [IDX_W-1:0]      col_pos_r;
  logic [ROW_W-1:0]      row_pos_r;
  logic                  at_last_col;
  logic                  at_last_row;
  logic                  in_acc;

  flush_state_t          fl_st_r, fl_nxt;
  logic [IDX_W-1:0]      drain_idx_r;
  logic                  issue_pend;
  logic                  issue_drain;

  logic [2*SAMPLE_W-1:0] line_mem [MAX_COLUMNS];
  logic [2*SAMPLE_W-1:0] rd_data_r;
  logic [2*SAMPLE_W-1:0] rd_eff;
  logic [2*SAMPLE_W-1:0] wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  s1_writes;
  logic                  fwd_hit;

  logic                  s1_v_r;
  item_kind_t            s1_kind_r, s1_kind_nxt;
  logic [SAMPLE_W-1:0]   s1_sample_r;
  logic [IDX_W-1:0]      s1_col_r;
  logic                  s1_emit_r, s1_emit_nxt;
  logic                  s1_interior_r, s1_interior_nxt;
  logic                  s1_first_r, s1_first_nxt;
  logic                  s1_cap_r, s1_cap_nxt;
  logic                  s1_last_r, s1_last_nxt;
  logic                  s1_fwd_r;
  logic [2*SAMPLE_W-1:0] s1_fwd_data_r;

  logic [SAMPLE_W-1:0]   win_r [WIN_N][WIN_N];
  logic [SAMPLE_W-1:0]   lastcol_r;

  logic                  s2_v_r;
  logic [SAMPLE_W-1:0]   s2_pass_r, s2_pass_nxt;
  logic                  s2_interior_r;
  logic                  s2_last_r;

  logic                  s3_v_r;
  logic [SUM_W-1:0]      s3_sum_r;
  logic [SUM_W-1:0]      win_sum;
  logic [SAMPLE_W-1:0]   s3_pass_r;
  logic                  s3_interior_r;
  logic                  s3_last_r;
  logic [PROD_W-1:0]     prod;

  logic                  out_tvalid_r;
  logic [SAMPLE_W-1:0]   out_tdata_r;
  logic                  out_tlast_r;

  logic                  load1;
  logic                  s1_free;
  logic                  adv1;
  logic                  adv2;
  logic                  adv3;

  always_comb begin
    rows_eff = (row_count_r == '0) ? ROW_W'(1) : row_count_r;
    row_last = rows_eff - ROW_W'(1);
    if (column_count_r == '0) begin
      cols_eff = COL_W'(1);
    end else if (column_count_r > MAX_COLS) begin
      cols_eff = MAX_COLS;
    end else begin
      cols_eff = column_count_r;
    end
    cols_m1  = cols_eff - COL_W'(1);
    col_last = cols_m1[IDX_W-1:0];
  end

  assign at_last_col = (col_pos_r == col_last);
  assign at_last_row = (row_pos_r == row_last);

  assign adv3    = s3_v_r && (!out_tvalid_r || out_tready);
  assign adv2    = s2_v_r && (!s3_v_r || adv3);
  assign adv1    = s1_v_r && (!s2_v_r || adv2);
  assign s1_free = !s1_v_r || adv1;

  assign in_tready = (fl_st_r == FL_IDLE) && s1_free;
  assign in_acc    = in_tvalid && in_tready;
  assign load1     = in_acc || issue_pend || issue_drain;

  always_comb begin
    fl_nxt = fl_st_r;
    unique case (fl_st_r)
      FL_IDLE: begin
        if (in_acc && at_last_col && at_last_row) begin
          fl_nxt = (rows_eff != ROW_W'(1)) ? FL_PEND : FL_DRAIN;
        end
      end
      FL_PEND: begin
        if (s1_free) begin
          fl_nxt = FL_DRAIN;
        end
      end
      FL_DRAIN: begin
        if (s1_free && drain_idx_r == col_last) begin
          fl_nxt = FL_IDLE;
        end
      end
      default: fl_nxt = FL_IDLE;
    endcase
  end

  always_comb begin
    issue_pend  = 1'b0;
    issue_drain = 1'b0;
    unique case (fl_st_r)
      FL_IDLE:  ;
      FL_PEND:  issue_pend  = s1_free;
      FL_DRAIN: issue_drain = s1_free;
      default:  ;
    endcase
  end

  assign rd_addr   = (fl_st_r == FL_DRAIN) ? drain_idx_r : col_pos_r;
  assign rd_eff    = s1_fwd_r ? s1_fwd_data_r : rd_data_r;
  assign wr_data   = {rd_eff[SAMPLE_W-1:0], s1_sample_r};
  assign s1_writes = adv1 && (s1_kind_r == K_NORMAL);
  assign fwd_hit   = s1_writes && (s1_col_r == rd_addr);

  always_comb begin
    s1_kind_nxt     = K_NORMAL;
    s1_emit_nxt     = 1'b1;
    s1_interior_nxt = 1'b0;
    s1_first_nxt    = 1'b0;
    s1_cap_nxt      = 1'b0;
    s1_last_nxt     = 1'b0;
    if (in_acc) begin
      s1_emit_nxt     = ((col_pos_r == '0) && (row_pos_r >= ROW_W'(2))) ||
                        ((col_pos_r != '0) && (row_pos_r != '0));
      s1_interior_nxt = (col_pos_r >= IDX_W'(2)) && (row_pos_r >= ROW_W'(2));
      s1_first_nxt    = (col_pos_r == '0);
      s1_cap_nxt      = at_last_col;
    end else if (issue_pend) begin
      s1_kind_nxt = K_PEND;
    end else begin
      s1_kind_nxt = K_DRAIN;
      s1_last_nxt = (drain_idx_r == col_last);
    end
  end

  always_comb begin
    unique case (s1_kind_r)
      K_NORMAL: s2_pass_nxt = s1_first_r ? lastcol_r : win_r[1][WIN_N-1];
      K_PEND:   s2_pass_nxt = lastcol_r;
      K_DRAIN:  s2_pass_nxt = rd_eff[SAMPLE_W-1:0];
      default:  s2_pass_nxt = rd_eff[SAMPLE_W-1:0];
    endcase
  end

  always_comb begin
    win_sum = '0;
    for (int k = 0; k < WIN_N; k++) begin
      for (int j = 0; j < WIN_N; j++) begin
        win_sum = win_sum + SUM_W'(win_r[k][j]);
      end
    end
  end

  assign prod = PROD_W'(s3_sum_r) * PROD_W'(DIV9_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_wdata[ROW_W-1:0];
        REG_COLUMN_COUNT: column_count_r <= cfg_wdata[COL_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      fl_st_r     <= FL_IDLE;
      drain_idx_r <= '0;
    end else if (cfg_we) begin
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      fl_st_r     <= FL_IDLE;
      drain_idx_r <= '0;
    end else begin
      fl_st_r <= fl_nxt;
      if (in_acc) begin
        if (at_last_col && at_last_row) begin
          col_pos_r   <= '0;
          row_pos_r   <= '0;
          drain_idx_r <= '0;
        end else if (at_last_col) begin
          col_pos_r <= '0;
          row_pos_r <= row_pos_r + ROW_W'(1);
        end else begin
          col_pos_r <= col_pos_r + IDX_W'(1);
        end
      end
      if (issue_drain) begin
        drain_idx_r <= drain_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_writes) begin
      line_mem[s1_col_r] <= wr_data;
    end
    if (load1) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load1) begin
        s1_v_r <= 1'b1;
      end else if (adv1) begin
        s1_v_r <= 1'b0;
      end
      if (adv1) begin
        s2_v_r <= s1_emit_r;
      end else if (adv2) begin
        s2_v_r <= 1'b0;
      end
      if (adv2) begin
        s3_v_r <= 1'b1;
      end else if (adv3) begin
        s3_v_r <= 1'b0;
      end
      if (adv3) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_kind_r     <= s1_kind_nxt;
      s1_sample_r   <= in_tdata;
      s1_col_r      <= rd_addr;
      s1_emit_r     <= s1_emit_nxt;
      s1_interior_r <= s1_interior_nxt;
      s1_first_r    <= s1_first_nxt;
      s1_cap_r      <= s1_cap_nxt;
      s1_last_r     <= s1_last_nxt;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= wr_data;
    end
    if (s1_writes) begin
      for (int k = 0; k < WIN_N; k++) begin
        for (int j = 0; j < WIN_N-1; j++) begin
          win_r[k][j] <= win_r[k][j+1];
        end
      end
      win_r[0][WIN_N-1] <= rd_eff[2*SAMPLE_W-1:SAMPLE_W];
      win_r[1][WIN_N-1] <= rd_eff[SAMPLE_W-1:0];
      win_r[2][WIN_N-1] <= s1_sample_r;
      if (s1_cap_r) begin
        lastcol_r <= rd_eff[SAMPLE_W-1:0];
      end
    end
    if (adv1) begin
      s2_pass_r     <= s2_pass_nxt;
      s2_interior_r <= s1_interior_r && (s1_kind_r == K_NORMAL);
      s2_last_r     <= s1_last_r;
    end
    if (adv2) begin
      s3_sum_r      <= win_sum;
      s3_pass_r     <= s2_pass_r;
      s3_interior_r <= s2_interior_r;
      s3_last_r     <= s2_last_r;
    end
    if (adv3) begin
      out_tdata_r <= s3_interior_r ? prod[DIV_SHIFT+SAMPLE_W-1:DIV_SHIFT] : s3_pass_r;
      out_tlast_r <= s3_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_flush_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (fl_st_r != FL_IDLE && $past(fl_st_r) == FL_IDLE) |-> $past(in_tvalid && in_tready))
    else $error("flush started without a final input word");

  a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fl_st_r == FL_DRAIN) |-> (drain_idx_r <= col_last))
    else $error("drain index beyond the last column");

  a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_last_r) |-> !s3_interior_r)
    else $error("frame end marked on a filtered word");

endmodule
